[rtl/core/chs_pkg.sv]
`default_nettype none

package chs_pkg;

  localparam int BUCKETS_DEF    = 10;
  localparam int POOL_NODES_DEF = 64;
  localparam int KEY_BITS_DEF   = 32;
  localparam int KEY_PORT_W     = 32;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_HEAD_RD,
    S_INSERT,
    S_LOAD,
    S_TEST,
    S_CMP
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic load_req;
    logic mod_step;
    logic head_rd;
    logic insert;
    logic load_cursor;
    logic node_rd;
    logic follow;
    logic finish;
    logic res_found;
    logic res_stored;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic mod_last;
    logic is_search;
    logic full;
    logic cur_valid;
    logic key_match;
  } ctl_status_t;

endpackage

`default_nettype wire

[rtl/core/chs_ctrl.sv]
`default_nettype none

module chs_ctrl
  import chs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire ctl_status_t status,
  output ctl_cmd_t         cmd,
  output logic             busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_MOD;
      end
      S_MOD: begin
        if (status.mod_last) state_next = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        state_next = (status.is_search == REQ_SEARCH) ? S_LOAD : S_INSERT;
      end
      S_INSERT: begin
        state_next = S_IDLE;
      end
      S_LOAD: begin
        state_next = S_TEST;
      end
      S_TEST: begin
        state_next = status.cur_valid ? S_CMP : S_IDLE;
      end
      S_CMP: begin
        state_next = status.key_match ? S_IDLE : S_TEST;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
      end
      S_IDLE: begin
        busy         = 1'b0;
        cmd.load_req = start;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
      end
      S_HEAD_RD: begin
        cmd.head_rd = 1'b1;
      end
      S_INSERT: begin
        cmd.insert     = !status.full;
        cmd.finish     = 1'b1;
        cmd.res_stored = !status.full;
      end
      S_LOAD: begin
        cmd.load_cursor = 1'b1;
      end
      S_TEST: begin
        if (status.cur_valid) begin
          cmd.node_rd = 1'b1;
        end else begin
          cmd.finish = 1'b1;
        end
      end
      S_CMP: begin
        if (status.key_match) begin
          cmd.finish    = 1'b1;
          cmd.res_found = 1'b1;
        end else begin
          cmd.follow = 1'b1;
        end
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/chs_datapath.sv]
`default_nettype none

module chs_datapath
  import chs_pkg::*;
#(
  parameter int BUCKETS    = BUCKETS_DEF,
  parameter int POOL_NODES = POOL_NODES_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_type,
  input  wire logic [KEY_PORT_W-1:0] key,
  input  wire ctl_cmd_t              cmd,
  output ctl_status_t                status,
  output logic                       done,
  output logic                       found,
  output logic                       stored
);

  localparam int KW        = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
  localparam int MOD_STEPS = 2;
  localparam int SCW       = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
  localparam int RW        = $clog2(BUCKETS);
  localparam int PW        = $clog2(POOL_NODES);
  localparam int QS        = KW + RW;
  localparam int PRW       = 2 * KW + 1;
  localparam logic [63:0]   RECIP_L    =
    ((64'd1 << QS) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [KW:0]   RECIP      = RECIP_L[KW:0];
  localparam logic [RW-1:0] BUCKETS_LO = RW'(BUCKETS);
  localparam logic [PW:0]  POOL_W     = (PW + 1)'(POOL_NODES);
  localparam logic [RW-1:0] CLR_LAST  = RW'(BUCKETS - 1);
  localparam logic [SCW-1:0] MOD_LAST = SCW'(MOD_STEPS - 1);

  logic [KW-1:0]  key_q;
  logic           req_q;
  logic [PRW-1:0] prod;
  logic [RW-1:0]  quot_lo;
  logic [SCW-1:0] step_cnt;
  logic [RW-1:0]  bucket;
  logic [RW-1:0]  clr_cnt;
  logic [PW:0]    nodes_used;
  logic [PW:0]    head_q;
  logic [PW:0]    cur;
  logic [KW-1:0]  node_key_q;
  logic [PW:0]    link_q;

  logic [PW:0]    head_mem [BUCKETS];
  logic [KW-1:0]  node_key_mem [POOL_NODES];
  logic [PW:0]    node_link_mem [POOL_NODES];

  // remainder by the bucket count: reciprocal multiply, then the low quotient bits
  always_comb begin
    quot_lo = RW'(KW'(prod >> QS));
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      key_q    <= key[KW-1:0];
      req_q    <= req_type;
      step_cnt <= '0;
    end else if (cmd.mod_step) begin
      prod     <= PRW'(key_q) * PRW'(RECIP);
      step_cnt <= step_cnt + 1'b1;
      bucket   <= RW'(key_q) - quot_lo * BUCKETS_LO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      nodes_used <= '0;
    end else begin
      if (cmd.clear_wr) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.insert) nodes_used <= nodes_used + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      head_mem[clr_cnt] <= '0;
    end else if (cmd.insert) begin
      head_mem[bucket] <= {1'b1, nodes_used[PW-1:0]};
    end
    if (cmd.head_rd) head_q <= head_mem[bucket];
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      node_key_mem[nodes_used[PW-1:0]]  <= key_q;
      node_link_mem[nodes_used[PW-1:0]] <= head_q;
    end
    if (cmd.node_rd) begin
      node_key_q <= node_key_mem[cur[PW-1:0]];
      link_q     <= node_link_mem[cur[PW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_cursor) begin
      cur <= head_q;
    end else if (cmd.follow) begin
      cur <= link_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    found  <= cmd.res_found;
    stored <= cmd.res_stored;
  end

  always_comb begin
    status.clear_last = (clr_cnt == CLR_LAST);
    status.mod_last   = (step_cnt == MOD_LAST);
    status.is_search  = req_q;
    status.full       = (nodes_used == POOL_W);
    status.cur_valid  = cur[PW];
    status.key_match  = (node_key_q == key_q);
  end

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= POOL_W)
    else $error("node count past pool size");

  a_no_insert_full: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !status.full && cmd.finish)
    else $error("node written with pool full");

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> !(found && stored))
    else $error("found and stored together");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe on back to back cycles");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |=> nodes_used == $past(nodes_used) + 1'b1)
    else $error("node count not advanced on insert");

endmodule

`default_nettype wire

[rtl/core/chained_hash_set_core.sv]
// insert: strobes its result after the bucket remainder (reciprocal multiply, then
//   low-bit fixup), a head read and a link write
// search: after the head read, a node memory read then a compare for each chain node,
//   on a hit or a miss; a new beat is taken in the strobe cycle
// reset: a clearing pass writes every bucket head empty, one per cycle, with busy high;
//   the receiver cannot stall, the result beat lasts one cycle
`default_nettype none

module chained_hash_set_core
  import chs_pkg::*;
#(
  parameter int BUCKETS    = BUCKETS_DEF,
  parameter int POOL_NODES = POOL_NODES_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  req_type,
  input  wire logic [KEY_PORT_W-1:0] key,
  output logic                       done,
  output logic                       found,
  output logic                       stored
);

  ctl_cmd_t    cmd;
  ctl_status_t status;

  chs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  chs_datapath #(
    .BUCKETS    (BUCKETS),
    .POOL_NODES (POOL_NODES),
    .KEY_BITS   (KEY_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .req_type (req_type),
    .key      (key),
    .cmd      (cmd),
    .status   (status),
    .done     (done),
    .found    (found),
    .stored   (stored)
  );

endmodule

`default_nettype wire
